/* rtl/core/skt_pkg.sv */
// skt_pkg: shared widths, operation codes and controller/datapath interface types
// for the sorted key table; no dependencies
package skt_pkg;

  localparam int KEY_W               = 16;
  localparam int HANDLE_W            = 32;
  localparam int POS_W               = 6;
  localparam int CNT_W               = 7;
  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  // read step of the scan cursor
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_UP   = 2'd1,
    RD_DOWN = 2'd2
  } rd_kind_t;

  // memory write selection
  typedef enum logic [1:0] {
    WR_NONE      = 2'd0,
    WR_SHIFT     = 2'd1,  // move the entry just read one place up
    WR_NEW_ABOVE = 2'd2,  // new entry just above the entry just read
    WR_NEW_ZERO  = 2'd3   // new entry at the bottom of the table
  } wr_kind_t;

  // result to post
  typedef enum logic [2:0] {
    RES_NONE = 3'd0,
    RES_MISS = 3'd1,
    RES_FULL = 3'd2,
    RES_HIT  = 3'd3,
    RES_INS  = 3'd4
  } res_kind_t;

  typedef struct packed {
    logic      load;
    rd_kind_t  rd;
    wr_kind_t  wr;
    res_kind_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic op_find;
    logic cnt_zero;
    logic cnt_full;
    logic key_eq;
    logic key_gt;
    logic cmp_at_zero;
    logic cur_at_end;
  } dp_stat_t;

endpackage

/* rtl/core/sorted_key_table.sv */
// sorted_key_table: top level, joins the sequencer and the entry datapath
// depends on skt_pkg, skt_ctrl, skt_dp
//
// channel   handshake        payload
// command   start / busy     operation, year_key, record_handle
// result    done (strobe)    found, position, handle_out, entry_count, table_full
//
// a transaction is taken when start is high and busy is low; one result follows
// a find scans up from index 0 to a matching key or the entry count; empty: no scan
// an insert scans down from the top entry; full or empty table: no scan
// the scan is set by the single read port of the entry memory, one entry a cycle
// rst clears the entry count; entry memories are not cleared
// done stays high one cycle only: the receiver cannot stall
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  logic signed [KEY_W-1:0] year_key,
  input  logic [HANDLE_W-1:0]     record_handle,
  output logic                    done,
  output logic                    found,
  output logic [POS_W-1:0]        position,
  output logic [HANDLE_W-1:0]     handle_out,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    table_full
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  skt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .operation     (operation),
    .year_key      (year_key),
    .record_handle (record_handle),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .found         (found),
    .position      (position),
    .handle_out    (handle_out),
    .entry_count   (entry_count),
    .table_full    (table_full)
  );

  // a result is posted only as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (!found && handle_out == '0))
    else $error("dropped insert reported as stored");

  a_cmd_only_busy: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cmd.wr == WR_NONE && cmd.res == RES_NONE))
    else $error("memory write or result issued while idle");

endmodule

/* rtl/core/skt_ctrl.sv */
// skt_ctrl: sequencer for find and ordered insert, drives datapath commands
// depends on skt_pkg
module skt_ctrl
  import skt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_FIND_CMP = 5'b00100,
    S_INS_CMP  = 5'b01000,
    S_INS_LAST = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.rd     = RD_NONE;
    cmd.wr     = WR_NONE;
    cmd.res    = RES_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_find) begin
          if (stat.cnt_zero) begin
            cmd.res    = RES_MISS;
            state_next = S_IDLE;
          end else begin
            cmd.rd     = RD_UP;
            state_next = S_FIND_CMP;
          end
        end else if (stat.cnt_full) begin
          cmd.res    = RES_FULL;
          state_next = S_IDLE;
        end else if (stat.cnt_zero) begin
          cmd.wr     = WR_NEW_ZERO;
          cmd.res    = RES_INS;
          state_next = S_IDLE;
        end else begin
          cmd.rd     = RD_DOWN;
          state_next = S_INS_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat.key_eq) begin
          cmd.res    = RES_HIT;
          state_next = S_IDLE;
        end else if (stat.cur_at_end) begin
          cmd.res    = RES_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.rd = RD_UP;
        end
      end
      S_INS_CMP: begin
        // walk down from the top, moving larger keys up one place
        if (stat.key_gt) begin
          cmd.wr = WR_SHIFT;
          if (stat.cmp_at_zero) begin
            state_next = S_INS_LAST;
          end else begin
            cmd.rd = RD_DOWN;
          end
        end else begin
          cmd.wr     = WR_NEW_ABOVE;
          cmd.res    = RES_INS;
          state_next = S_IDLE;
        end
      end
      S_INS_LAST: begin
        cmd.wr     = WR_NEW_ZERO;
        cmd.res    = RES_INS;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/core/skt_dp.sv */
// skt_dp: entry memories, scan cursor, entry count and result registers
// depends on skt_pkg
module skt_dp
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       operation,
  input  logic signed [KEY_W-1:0]    year_key,
  input  logic [HANDLE_W-1:0]        record_handle,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  output logic                       done,
  output logic                       found,
  output logic [POS_W-1:0]           position,
  output logic [HANDLE_W-1:0]        handle_out,
  output logic [CNT_W-1:0]           entry_count,
  output logic                       table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [HANDLE_W-1:0]     hdl_mem [TABLE_DEPTH];

  logic                    op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [HANDLE_W-1:0]     hdl_q;
  logic [CW-1:0]           count;
  logic [CW-1:0]           cur;
  logic [AW-1:0]           cmp_idx;
  logic signed [KEY_W-1:0] rd_key;
  logic [HANDLE_W-1:0]     rd_hdl;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_key;
  logic [HANDLE_W-1:0]     wr_hdl;
  logic [AW-1:0]           above_idx;
  logic [CW-1:0]           count_next;
  logic [AW+POS_W-1:0]     pos_wide;
  logic [CW+CNT_W-1:0]     cnt_wide;

  assign rd_en     = (cmd.rd != RD_NONE);
  assign rd_addr   = cur[AW-1:0];
  assign above_idx = cmp_idx + AW'(1);

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = above_idx;
    wr_key  = key_q;
    wr_hdl  = hdl_q;
    case (cmd.wr)
      WR_SHIFT: begin
        wr_key = rd_key;
        wr_hdl = rd_hdl;
      end
      WR_NEW_ABOVE: begin
      end
      WR_NEW_ZERO: begin
        wr_addr = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hdl_mem[wr_addr] <= wr_hdl;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_hdl <= hdl_mem[rd_addr];
    end
  end

  // cursor: finds walk up from zero, inserts walk down from the top entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      key_q <= year_key;
      hdl_q <= record_handle;
      cur   <= (operation == OP_FIND) ? '0 : count - CW'(1);
    end else if (cmd.rd == RD_UP) begin
      cur <= cur + CW'(1);
    end else if (cmd.rd == RD_DOWN) begin
      cur <= cur - CW'(1);
    end
    if (rd_en) begin
      cmp_idx <= rd_addr;
    end
  end

  assign count_next = (cmd.res == RES_INS) ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= (cmd.res != RES_NONE);
    end
  end

  always_comb begin
    pos_wide = '0;
    case (cmd.res)
      RES_HIT: pos_wide = {{POS_W{1'b0}}, cmp_idx};
      RES_INS: pos_wide = {{POS_W{1'b0}}, wr_addr};
      default: pos_wide = '0;
    endcase
  end

  assign cnt_wide = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.res != RES_NONE) begin
      found       <= (cmd.res == RES_HIT) || (cmd.res == RES_INS);
      table_full  <= (cmd.res == RES_FULL);
      position    <= pos_wide[POS_W-1:0];
      entry_count <= cnt_wide[CNT_W-1:0];
      case (cmd.res)
        RES_HIT: handle_out <= rd_hdl;
        RES_INS: handle_out <= hdl_q;
        default: handle_out <= '0;
      endcase
    end
  end

  assign stat.op_find     = (op_q == OP_FIND);
  assign stat.cnt_zero    = (count == '0);
  assign stat.cnt_full    = (count == CW'(TABLE_DEPTH));
  assign stat.key_eq      = (rd_key == key_q);
  assign stat.key_gt      = (rd_key > key_q);
  assign stat.cmp_at_zero = (cmp_idx == '0);
  assign stat.cur_at_end  = (cur == count);

endmodule
